// ----- rtl/assert_macros.svh -----
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/mfbp_pkg.sv -----
// shared types and constants of the msb first bit field packer
package mfbp_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int VALUE_BITS    = 32;
  localparam int COUNT_BITS    = 6;
  localparam int OUT_BITS      = 32;
  localparam int FIFO_DEPTH    = 2;

  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_PAD    = 1'b1
  } cmd_t;

endpackage

// ----- rtl/msb_first_bit_field_packer.sv -----
// top level of the msb first bit field packer
// a request that completes a word passes the queue and then the output register before it shows on m_axis
// throughput: one request per cycle while m_axis takes each word, set by the pack step of the back end
// a 2-entry queue separates front and back; the output register holds one word
// rst (synchronous) empties the queue, clears the partial word and the output valid
`include "assert_macros.svh"
module msb_first_bit_field_packer import mfbp_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // field_value[31:0], bit_count[37:32], zero fill
  input  logic [0:0]  s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // word_out
);

  localparam int CNT_W  = $clog2(WORD_BITS + 1);
  localparam int DATA_W = 1 + CNT_W + VALUE_BITS;
  localparam int QCNT_W = $clog2(FIFO_DEPTH + 1);

  cmd_t              in_cmd;
  logic              q_push;
  logic              q_push_ready;
  logic [DATA_W-1:0] q_push_data;
  logic              q_valid;
  logic              q_pop;
  logic [DATA_W-1:0] q_data;
  logic [QCNT_W-1:0] q_count;

  assign in_cmd = cmd_t'(s_axis_tuser[0]);

  mfbp_front #(
    .WORD_BITS (WORD_BITS),
    .CNT_W     (CNT_W)
  ) u_front (
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_cmd     (in_cmd),
    .in_value   (s_axis_tdata[VALUE_BITS-1:0]),
    .in_count   (s_axis_tdata[VALUE_BITS+COUNT_BITS-1:VALUE_BITS]),
    .push       (q_push),
    .push_ready (q_push_ready),
    .push_data  (q_push_data)
  );

  mfbp_fifo #(
    .DATA_W (DATA_W),
    .DEPTH  (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data),
    .count      (q_count)
  );

  mfbp_back #(
    .WORD_BITS (WORD_BITS),
    .CNT_W     (CNT_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_data    (q_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word  (m_axis_tdata)
  );

  // zero-length appends must be dropped before the queue
  `ASSERT_IMPLIES(a_zero_len_dropped, clk, rst, s_axis_tvalid && s_axis_tready && (in_cmd == CMD_APPEND) && (s_axis_tdata[VALUE_BITS+COUNT_BITS-1:VALUE_BITS] == '0), !q_push)
  // queue occupancy tracks a lone push
  `ASSERT_NEXT(a_queue_grows, clk, rst, q_push && !q_pop, q_count == $past(q_count) + 1'b1)
  // a new output word only ever follows a pop from the queue
  `ASSERT_IMPLIES(a_word_from_pop, clk, rst, $rose(m_axis_tvalid), $past(q_pop))

endmodule

// ----- rtl/mfbp_front.sv -----
// front end: classifies requests, saturates the bit count, masks the field
module mfbp_front import mfbp_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int CNT_W     = $clog2(WORD_BITS + 1)
) (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cmd_t                  in_cmd,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic [COUNT_BITS-1:0] in_count,
  output logic                  push,
  input  logic                  push_ready,
  output logic [CNT_W+VALUE_BITS:0] push_data
);

  logic [CNT_W-1:0]      n_sat;
  logic [VALUE_BITS:0]   mask_wide;
  logic [VALUE_BITS-1:0] v_masked;
  logic                  drop;

  always_comb begin
    if (32'(in_count) > 32'(WORD_BITS)) begin
      n_sat = CNT_W'(WORD_BITS);
    end else begin
      n_sat = CNT_W'(in_count);
    end
    mask_wide = ~({(VALUE_BITS + 1){1'b1}} << n_sat);
    v_masked  = in_value & mask_wide[VALUE_BITS-1:0];
    // a zero-length append changes nothing, so it never enters the queue
    drop      = (in_cmd == CMD_APPEND) && (n_sat == '0);
  end

  assign in_ready  = push_ready;
  assign push      = in_valid && push_ready && !drop;
  assign push_data = {in_cmd == CMD_PAD, n_sat, v_masked};

endmodule

// ----- rtl/mfbp_fifo.sv -----
// short request queue between front and back
module mfbp_fifo import mfbp_pkg::*; #(
  parameter int DATA_W = 40,
  parameter int DEPTH  = FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;

  assign push_ready = (32'(count) < 32'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && push_ready) begin
        wr_ptr <= (32'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && pop_valid) begin
        rd_ptr <= (32'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      case ({push && push_ready, pop && pop_valid})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/mfbp_back.sv -----
// back end: packs fields into the partial word and holds the output register
module mfbp_back import mfbp_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int CNT_W     = $clog2(WORD_BITS + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  output logic                      q_pop,
  input  logic [CNT_W+VALUE_BITS:0] q_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [OUT_BITS-1:0]       out_word
);

  localparam int OFF_W = $clog2(WORD_BITS);
  localparam int SUM_W = CNT_W + 1;
  localparam int MAXW  = (WORD_BITS > VALUE_BITS) ? WORD_BITS : VALUE_BITS;

  logic [WORD_BITS-1:0]  partial;
  logic [WORD_BITS-1:0]  partial_next;
  logic [OFF_W-1:0]      fill;
  logic [OFF_W-1:0]      fill_next;

  logic                  e_pad;
  logic [CNT_W-1:0]      e_n;
  logic [VALUE_BITS-1:0] e_val;
  logic [MAXW-1:0]       v_wide;
  logic [WORD_BITS-1:0]  v_ext;
  logic [SUM_W-1:0]      sum;
  logic [SUM_W-1:0]      rem_wide;
  logic [OFF_W-1:0]      rem;
  logic                  below;
  logic                  emit;
  logic [WORD_BITS-1:0]  emit_word;
  logic [MAXW-1:0]       emit_wide;

  assign {e_pad, e_n, e_val} = q_data;
  assign q_pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    v_wide       = MAXW'(e_val);
    v_ext        = v_wide[WORD_BITS-1:0];
    sum          = SUM_W'(fill) + SUM_W'(e_n);
    below        = sum < SUM_W'(WORD_BITS);
    rem_wide     = sum - SUM_W'(WORD_BITS);
    rem          = rem_wide[OFF_W-1:0];
    emit         = 1'b0;
    emit_word    = partial;
    partial_next = partial;
    fill_next    = fill;
    if (e_pad) begin
      if (fill != '0) begin
        emit         = 1'b1;
        partial_next = '0;
        fill_next    = '0;
      end
    end else if (below) begin
      partial_next = partial | (v_ext << (SUM_W'(WORD_BITS) - sum));
      fill_next    = sum[OFF_W-1:0];
    end else begin
      // field reaches the boundary: high part closes this word, low rem bits carry
      emit         = 1'b1;
      emit_word    = partial | (v_ext >> rem);
      partial_next = v_ext << (SUM_W'(WORD_BITS) - SUM_W'(rem));
      fill_next    = rem;
    end
    emit_wide = MAXW'(emit_word);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial   <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        partial <= partial_next;
        fill    <= fill_next;
      end
      if (q_pop && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      out_word <= emit_wide[OUT_BITS-1:0];
    end
  end

endmodule
